FILE: rtl/i2d_pkg.sv
// Package for the signed 32-bit integer to decimal ASCII unit.
// Holds the sequencer state type, character codes and the BCD adjust function.
// No dependencies.
`default_nettype none

package i2d_pkg;

  // Widths of the data path
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned BcdWidth    = 4 * NumDigits;
  localparam int unsigned CharWidth   = 6;
  localparam int unsigned InBytesW    = 32;
  localparam int unsigned OutBytesW   = 8;

  // ASCII codes, truncated to the 6-bit character field
  localparam logic [CharWidth-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CharWidth-1:0] CHAR_ZERO  = 6'd48;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Double-dabble correction: add 3 to a BCD digit of 5 or more before the shift
  function automatic logic [3:0] dd_adjust(input logic [3:0] dig);
    dd_adjust = (dig >= 4'd5) ? 4'(dig + 4'd3) : dig;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/int32_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// Depends on i2d_pkg (state type, character codes, BCD adjust function).
//
// Usage:
//   Input stream (s_axis_*): one word carries one signed 32-bit integer.
//   Output stream (m_axis_*): the decimal text of that integer, most significant
//   character first, '-' ahead of a negative value, no leading zeros, and
//   tlast high on the final character. Each input word gives 1 to 11 words.
//   Conversion is a bit-serial binary-to-BCD shift (double dabble): the
//   magnitude enters a 40-bit BCD register one bit per cycle.
//   Leading zero digits are then shifted out one per cycle, and one
//   character is emitted per cycle while the output is not stalled, each
//   digit from the top BCD digit. The first character is shown once the
//   conversion shift and the zero skip are done after the input word is
//   accepted (fewer digits mean more zero-skip steps). A new input word is
//   taken only after the previous word's conversion and skip/emit sweep.
//   The output word sits in a register: after the last character is loaded
//   the unit takes the next input word while that character still waits.
//   A stall on m_axis_tready holds the current character and the sign and digit states.
//   Reset (rst_ni low, asynchronous) returns the unit to idle and drops
//   m_axis_tvalid; any partly sent text is discarded.
`default_nettype none

module int32_to_decimal_ascii_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input stream; tdata: [31:0] value
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [i2d_pkg::InBytesW-1:0] s_axis_tdata,
  // Output stream; tdata: [5:0] character, [7:6] zero
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [i2d_pkg::OutBytesW-1:0] m_axis_tdata,
  output      logic                        m_axis_tlast
);
  import i2d_pkg::*;

  state_e                  state_q, state_d;
  logic [ValueWidth-1:0]   mag_q, mag_d;
  logic [BcdWidth-1:0]     bcd_q, bcd_d;
  logic [BcdWidth-1:0]     bcd_adj;
  logic                    neg_q, neg_d;
  logic [3:0]              cnt_q, cnt_d;
  logic [4:0]              bit_q, bit_d;
  logic                    out_valid_q, out_valid_d;
  logic [CharWidth-1:0]    out_char_q, out_char_d;
  logic                    out_last_q, out_last_d;

  logic                    in_acc;
  logic                    out_free;
  logic [3:0]              top_dig;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign top_dig       = bcd_q[BcdWidth-1 -: 4];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutBytesW-CharWidth){1'b0}}, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // Per-digit double-dabble correction
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = dd_adjust(bcd_q[4*i +: 4]);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (bit_q == 5'(ValueWidth - 1)) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(top_dig == 4'd0 && cnt_q > 4'd1)) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_free && cnt_q == 4'd1) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Data path and output register
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d = s_axis_tdata[ValueWidth-1];
          mag_d = s_axis_tdata[ValueWidth-1] ? ValueWidth'(~s_axis_tdata + 32'd1)
                                             : s_axis_tdata[ValueWidth-1:0];
          bcd_d = '0;
          bit_d = '0;
        end
      end
      ST_CONV: begin
        // Shift one magnitude bit into the corrected BCD register
        bcd_d = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
        mag_d = {mag_q[ValueWidth-2:0], 1'b0};
        bit_d = 5'(bit_q + 5'd1);
        cnt_d = 4'(NumDigits);
      end
      ST_SKIP: begin
        // Drop a leading zero digit, keep at least one
        if (top_dig == 4'd0 && cnt_q > 4'd1) begin
          bcd_d = {bcd_q[BcdWidth-5:0], 4'd0};
          cnt_d = 4'(cnt_q - 4'd1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO | {2'b00, top_dig};
          out_last_d  = (cnt_q == 4'd1);
          bcd_d       = {bcd_q[BcdWidth-5:0], 4'd0};
          cnt_d       = 4'(cnt_q - 4'd1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    cnt_q      <= cnt_d;
    bit_q      <= bit_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

`ifndef SYNTHESIS
  // An accepted word always starts a fresh conversion at bit zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CONV) && (bit_q == 5'd0))
    else $error("conversion did not start after input word");

  // Emitted digits are valid BCD
  a_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (top_dig <= 4'd9))
    else $error("digit out of BCD range");

  // The digit counter never runs out while digits remain to send
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_DIGIT) |-> (cnt_q != 4'd0))
    else $error("digit counter underflow");

  // A word held back by the receiver keeps its character and flag
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=>
      (out_valid_q && $stable(out_char_q) && $stable(out_last_q)))
    else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire
